// ===== hdl/xsrd_pkg.sv =====
// Package for the xorshift64* range draw core.
// Holds the sequencer states, the generator constants and the
// control and status structs shared with the remainder unit.
package xsrd_pkg;

  localparam int unsigned StateW = 64;
  localparam int unsigned BoundW = 32;
  localparam int unsigned SpanW  = BoundW + 1;

  localparam logic [StateW-1:0] MixMult = 64'h2545_F491_4F6C_DD1D;
  localparam int unsigned ShiftA = 12;
  localparam int unsigned ShiftB = 25;
  localparam int unsigned ShiftC = 27;

  localparam logic [StateW-1:0] SeedReset = 64'd1;

  // Register indexes on the configuration port.
  localparam logic RegSeed = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_MOD,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic start;
  } mod_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_sts_t;

  // One xorshift64 step.
  function automatic logic [StateW-1:0] xs_advance(input logic [StateW-1:0] s);
    logic [StateW-1:0] x;
    x = s;
    x = x ^ (x >> ShiftA);
    x = x ^ (x << ShiftB);
    x = x ^ (x >> ShiftC);
    return x;
  endfunction

endpackage

// ===== hdl/xsrd_if.sv =====
// Handshake channels of the xorshift64* range draw core.
// The request carries the two bounds, the response the drawn value and
// the generator state; no package dependency.
interface xsrd_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  modport source(output valid, range_low, range_high, input ready);
  modport sink(input valid, range_low, range_high, output ready);
endinterface

interface xsrd_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [63:0] state_after;

  modport source(output valid, value, state_after, input ready);
  modport sink(input valid, value, state_after, output ready);
endinterface

// ===== hdl/xorshift64_star_range_draw_core.sv =====
// xorshift64* range draw core: one signed 32-bit draw per request item.
// The accepting edge orders the bounds and advances the state. From acceptance to the result,
// the shared 32x32 multiplier builds the product, the bit-serial remainder unit is started,
// it runs 64 remainder steps, and the result is handed off to the output register.
// One item at a time; the next item can be taken the cycle after the result is
// registered. Synchronous reset loads the state with one.
module xorshift64_star_range_draw_core
  import xsrd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  xsrd_req_if.sink      req,
  xsrd_rsp_if.source    rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  // Generator state and the per-item working registers.
  logic [StateW-1:0] gen_state;
  logic signed [BoundW-1:0] lo;
  logic [SpanW-1:0]  span;
  logic [1:0]        mstep;
  logic [StateW-1:0] prod;
  logic [StateW-1:0] acc;

  // Output register: the result waits here until the sink takes it.
  logic                     out_valid;
  logic signed [BoundW-1:0] out_value;
  logic [StateW-1:0]        out_state;

  seq_state_t state, state_next;

  mod_ctl_t          mctl;
  mod_sts_t          msts;
  logic [BoundW-1:0] mrem;

  logic cfg_wr;
  logic accept;
  logic out_load;

  // Bound ordering and span: span = high - low + 1, up to 2^32.
  logic signed [BoundW-1:0] b_lo, b_hi;
  logic [SpanW-1:0]         b_diff;

  // Multiplier operands for the three partial products that reach the
  // low 64 bits of state * constant.
  logic [BoundW-1:0] mul_a, mul_b;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  // Only the seed register exists; it answers wherever paddr[3] is clear, other addresses read as zero.
  assign prdata = (paddr[3] == RegSeed) ? gen_state : '0;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid       = out_valid;
  assign rsp.value       = out_value;
  assign rsp.state_after = out_state;

  always_comb begin
    if (req.range_low > req.range_high) begin
      b_lo = req.range_high;
      b_hi = req.range_low;
    end else begin
      b_lo = req.range_low;
      b_hi = req.range_high;
    end
    b_diff = {b_hi[BoundW-1], b_hi} - {b_lo[BoundW-1], b_lo};
  end

  always_comb begin
    case (mstep)
      2'd0: begin
        mul_a = gen_state[BoundW-1:0];
        mul_b = MixMult[BoundW-1:0];
      end
      2'd1: begin
        mul_a = gen_state[BoundW-1:0];
        mul_b = MixMult[StateW-1:BoundW];
      end
      default: begin
        mul_a = gen_state[StateW-1:BoundW];
        mul_b = MixMult[BoundW-1:0];
      end
    endcase
  end

  // The result leaves the pipeline once the output register is free.
  assign out_load = (state == S_OUT) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    mctl.start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        // Step three folds in the last partial product and hands the
        // finished product to the remainder unit.
        if (mstep == 2'd3) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (msts.done) begin
          state_next = S_OUT;
        end
        mctl.start = !msts.busy && !msts.done && (mstep == 2'd0);
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= SeedReset;
      out_valid <= 1'b0;
      mstep     <= '0;
    end else begin
      if (cfg_wr && (paddr[3] == RegSeed)) begin
        // A zero seed would lock the generator, so it loads as one.
        gen_state <= (pwdata == '0) ? SeedReset : pwdata;
      end

      if (accept) begin
        gen_state <= xs_advance(gen_state);
        lo        <= b_lo;
        span      <= b_diff + 1'b1;
        mstep     <= '0;
      end

      if (state == S_MUL) begin
        // A register stands after the multiplier; each product is added
        // in the following cycle.
        prod  <= mul_a * mul_b;
        mstep <= mstep + 1'b1;
        if (mstep == 2'd1) begin
          acc <= prod;
        end else if (mstep != 2'd0) begin
          acc[StateW-1:BoundW] <= acc[StateW-1:BoundW] + prod[BoundW-1:0];
        end
      end

      if (state == S_MOD) begin
        mstep <= 2'd1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
        out_value <= lo + $signed(mrem);
        out_state <= gen_state;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  xsrd_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mctl),
    .dividend  (acc),
    .divisor   (span),
    .sts       (msts),
    .remainder (mrem)
  );

endmodule

// ===== hdl/xsrd_mod_unit.sv =====
// Bit-serial restoring remainder unit: 64-bit dividend by a 33-bit divisor.
// Depends on xsrd_pkg for widths and the control and status structs.
module xsrd_mod_unit
  import xsrd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  mod_ctl_t            ctl,
  input  logic [StateW-1:0]   dividend,
  input  logic [SpanW-1:0]    divisor,
  output mod_sts_t            sts,
  output logic [BoundW-1:0]   remainder
);

  localparam int unsigned CntW = $clog2(StateW);

  logic [StateW-1:0] dvd;
  logic [SpanW-1:0]  dsr;
  logic [SpanW-1:0]  rem;
  logic [CntW-1:0]   cnt;
  logic              busy;
  logic              done;

  logic [SpanW:0] trial;
  logic [SpanW:0] diff;

  // One quotient bit per cycle; the remainder always stays below the divisor.
  assign trial = {rem, dvd[StateW-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd <= dvd << 1;
        if (!diff[SpanW]) begin
          rem <= diff[SpanW-1:0];
        end else begin
          rem <= trial[SpanW-1:0];
        end
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(StateW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign remainder = rem[BoundW-1:0];

endmodule
